@@ design/fbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// fbcs_pkg: shared types and constants of the fault blink-code sequencer
// Request payloads, register map codes, phase and LED codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fbcs_pkg;

	typedef struct packed {
		logic [3:0] fault_code;
		logic       miss_right;
		logic       miss_left;
		logic       miss_pwm;
		logic       button;
	} in_t;

	typedef struct packed {
		logic red_led;
		logic green_led;
		logic start_calibration;
	} out_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned CODE_W = 4;

	// register indexes, paddr[4:2]
	localparam logic [2:0] REG_ON_MS      = 3'd0;
	localparam logic [2:0] REG_OFF_MS     = 3'd1;
	localparam logic [2:0] REG_PAUSE_MS   = 3'd2;
	localparam logic [2:0] REG_LONG_PRESS = 3'd3;
	localparam logic [2:0] REG_GENERAL    = 3'd4;
	localparam logic [2:0] REG_NEUTRAL    = 3'd5;
	localparam logic [2:0] REG_NO_GAMEPAD = 3'd6;

	localparam logic [TICK_W-1:0] RST_ON_MS      = 16'd1000;
	localparam logic [TICK_W-1:0] RST_OFF_MS     = 16'd1000;
	localparam logic [TICK_W-1:0] RST_PAUSE_MS   = 16'd4000;
	localparam logic [TICK_W-1:0] RST_LONG_PRESS = 16'd5000;
	localparam logic [CODE_W-1:0] RST_GENERAL    = 4'd5;
	localparam logic [CODE_W-1:0] RST_NEUTRAL    = 4'd7;
	localparam logic [CODE_W-1:0] RST_NO_GAMEPAD = 4'd8;

	localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

	// series phases
	localparam logic [1:0] PH_LIT   = 2'd0;
	localparam logic [1:0] PH_DARK  = 2'd1;
	localparam logic [1:0] PH_PAUSE = 2'd2;

	// LED drive, bit0 red, bit1 green
	localparam logic [1:0] LED_OFF   = 2'b00;
	localparam logic [1:0] LED_RED   = 2'b01;
	localparam logic [1:0] LED_GREEN = 2'b10;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

endpackage

`default_nettype wire

@@ design/fault_blink_code_sequencer.sv @@
// ----------------------------------------------------------------------------
// fault_blink_code_sequencer: LED blink-code fault indicator
// One millisecond tick request in, one LED/calibration result out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one tick request each: the current fault
//   code, three missing-device flags and the button level. Each accepted
//   request yields exactly one result on out_valid/out_ready/out_data
//   (red_led, green_led, start_calibration).
//   The result register is loaded at the edge that accepts the request, and
//   one request is taken per cycle while the receiver does not stall; the sequencer
//   state and all timers update in a single step from the registered state
//   through 16-bit compares into the result register.
//   in_ready is high whenever the result register is empty or is being
//   drained in the same cycle, so a stalled receiver stalls the input by
//   exactly one held result and no request is lost.
//   The APB port holds the timing registers and the special codes at byte
//   addresses 4*i; pready is always high. Program it only while idle.
//   Reset (arst_n low) loads the default register values, clears all
//   sequencer state (LEDs off, no series running) and empties the result
//   register.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_blink_code_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire fbcs_pkg::in_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output fbcs_pkg::out_t                      out_data,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [fbcs_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [fbcs_pkg::DATA_W-1:0]    pwdata,
	output logic [fbcs_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int unsigned TW = fbcs_pkg::TICK_W;
	localparam int unsigned CW = fbcs_pkg::CODE_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [TW-1:0] on_ms_q, off_ms_q, pause_ms_q, long_press_q;
	logic [CW-1:0] general_q, neutral_q, no_gamepad_q;
	logic [2:0]    reg_idx;
	logic          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_ms_q      <= fbcs_pkg::RST_ON_MS;
			off_ms_q     <= fbcs_pkg::RST_OFF_MS;
			pause_ms_q   <= fbcs_pkg::RST_PAUSE_MS;
			long_press_q <= fbcs_pkg::RST_LONG_PRESS;
			general_q    <= fbcs_pkg::RST_GENERAL;
			neutral_q    <= fbcs_pkg::RST_NEUTRAL;
			no_gamepad_q <= fbcs_pkg::RST_NO_GAMEPAD;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				fbcs_pkg::REG_ON_MS:      on_ms_q      <= pwdata[TW-1:0];
				fbcs_pkg::REG_OFF_MS:     off_ms_q     <= pwdata[TW-1:0];
				fbcs_pkg::REG_PAUSE_MS:   pause_ms_q   <= pwdata[TW-1:0];
				fbcs_pkg::REG_LONG_PRESS: long_press_q <= pwdata[TW-1:0];
				fbcs_pkg::REG_GENERAL:    general_q    <= pwdata[CW-1:0];
				fbcs_pkg::REG_NEUTRAL:    neutral_q    <= pwdata[CW-1:0];
				fbcs_pkg::REG_NO_GAMEPAD: no_gamepad_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fbcs_pkg::REG_ON_MS:      prdata = {{(32-TW){1'b0}}, on_ms_q};
			fbcs_pkg::REG_OFF_MS:     prdata = {{(32-TW){1'b0}}, off_ms_q};
			fbcs_pkg::REG_PAUSE_MS:   prdata = {{(32-TW){1'b0}}, pause_ms_q};
			fbcs_pkg::REG_LONG_PRESS: prdata = {{(32-TW){1'b0}}, long_press_q};
			fbcs_pkg::REG_GENERAL:    prdata = {{(32-CW){1'b0}}, general_q};
			fbcs_pkg::REG_NEUTRAL:    prdata = {{(32-CW){1'b0}}, neutral_q};
			fbcs_pkg::REG_NO_GAMEPAD: prdata = {{(32-CW){1'b0}}, no_gamepad_q};
			default:                  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	logic [CW-1:0] code_seen_q, flashes_done_q, flashes_target_q;
	logic          series_active_q, alt_flip_q, button_last_q;
	logic [1:0]    phase_q, detail_index_q, led_q;
	logic [TW-1:0] phase_ticks_q, alt_ticks_q, press_ticks_q;

	logic [CW-1:0] code_seen_n, flashes_done_n, flashes_target_n;
	logic          series_active_n, alt_flip_n, button_last_n;
	logic [1:0]    phase_n, detail_index_n, led_n;
	logic [TW-1:0] phase_ticks_n, alt_ticks_n, press_ticks_n;
	logic          cal_n;

	logic          out_valid_q;
	fbcs_pkg::out_t out_data_q;
	logic          in_acc;

	assign in_ready  = ~out_valid_q | out_ready;
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Round-robin pick of the next missing device, starting at the slot
	// after the one shown last. Falls back to the general code.
	logic [CW-1:0] detail_code;
	logic [1:0]    detail_next;
	logic [2:0]    miss_vec;

	assign miss_vec = {in_data.miss_pwm, in_data.miss_left, in_data.miss_right};

	always_comb begin
		logic       found;
		logic [2:0] slot;
		found       = 1'b0;
		slot        = '0;
		detail_code = general_q;
		detail_next = detail_index_q;
		for (int k = 0; k < 3; k++) begin
			slot = {1'b0, detail_index_q} + 3'(k);
			if (slot >= 3'd3)
				slot = slot - 3'd3;
			if (!found && miss_vec[slot[1:0]]) begin
				found       = 1'b1;
				detail_code = CW'(slot) + CW'(2);
				detail_next = (slot[1:0] == 2'd2) ? 2'd0 : slot[1:0] + 2'd1;
			end
		end
	end

	logic [TW-1:0] pt_inc, at_inc, prt_inc;
	assign pt_inc  = (phase_ticks_q == fbcs_pkg::TICK_MAX) ? phase_ticks_q : phase_ticks_q + 1'b1;
	assign at_inc  = (alt_ticks_q == fbcs_pkg::TICK_MAX) ? alt_ticks_q : alt_ticks_q + 1'b1;
	assign prt_inc = (press_ticks_q == fbcs_pkg::TICK_MAX) ? press_ticks_q : press_ticks_q + 1'b1;

	always_comb begin
		logic [CW-1:0] code;
		logic          btn, active, long_hit;
		logic [1:0]    ph;
		logic [TW-1:0] ticks;
		logic [CW-1:0] done_inc;
		logic [CW-1:0] restart_code;

		code     = in_data.fault_code;
		btn      = in_data.button;
		// a code change cancels the running series
		active   = series_active_q & (code == code_seen_q);
		long_hit = 1'b0;
		ph       = fbcs_pkg::PH_LIT;
		ticks    = '0;
		done_inc = '0;
		restart_code = code;

		code_seen_n      = code;
		series_active_n  = active;
		phase_n          = phase_q;
		phase_ticks_n    = pt_inc;
		flashes_done_n   = flashes_done_q;
		flashes_target_n = flashes_target_q;
		detail_index_n   = detail_index_q;
		alt_ticks_n      = at_inc;
		alt_flip_n       = alt_flip_q;
		button_last_n    = button_last_q;
		press_ticks_n    = prt_inc;
		led_n            = led_q;
		cal_n            = 1'b0;

		if (code == fbcs_pkg::CODE_NONE) begin
			series_active_n = 1'b0;
			led_n           = fbcs_pkg::LED_OFF;
		end else begin
			// neutral code: long-press detection; LEDs hold while it fires
			if (code == neutral_q) begin
				long_hit = btn & button_last_q & (prt_inc >= long_press_q);
				if (btn && !button_last_q)
					press_ticks_n = '0;
				if (long_hit) begin
					cal_n = 1'b1;
				end else begin
					if (!btn && button_last_q)
						press_ticks_n = '0;
					button_last_n = btn;
				end
			end

			if (!long_hit) begin
				if (code == no_gamepad_q) begin
					if (at_inc >= on_ms_q) begin
						alt_ticks_n = '0;
						alt_flip_n  = ~alt_flip_q;
					end
					led_n = (alt_flip_n) ? fbcs_pkg::LED_GREEN : fbcs_pkg::LED_RED;
				end else begin
					// idle series starts here with its first flash lit
					ph                = active ? phase_q : fbcs_pkg::PH_LIT;
					ticks             = active ? pt_inc : '0;
					series_active_n   = 1'b1;
					phase_n           = ph;
					phase_ticks_n     = ticks;
					flashes_done_n    = active ? flashes_done_q : '0;
					flashes_target_n  = active ? flashes_target_q : code;
					led_n             = active ? led_q : fbcs_pkg::LED_RED;
					done_inc          = flashes_done_n + 1'b1;

					if (code == general_q)
						restart_code = detail_code;
					else if (|miss_vec)
						restart_code = general_q;
					else
						restart_code = code;

					unique case (ph)
						fbcs_pkg::PH_LIT: begin
							if (ticks >= on_ms_q) begin
								led_n         = fbcs_pkg::LED_OFF;
								phase_ticks_n = '0;
								phase_n       = fbcs_pkg::PH_DARK;
							end
						end
						fbcs_pkg::PH_DARK: begin
							if (ticks >= off_ms_q) begin
								flashes_done_n = done_inc;
								phase_ticks_n  = '0;
								if (done_inc >= flashes_target_n) begin
									phase_n = fbcs_pkg::PH_PAUSE;
									led_n   = fbcs_pkg::LED_OFF;
								end else begin
									phase_n = fbcs_pkg::PH_LIT;
									led_n   = fbcs_pkg::LED_RED;
								end
							end
						end
						fbcs_pkg::PH_PAUSE: begin
							if (ticks >= pause_ms_q) begin
								phase_n          = fbcs_pkg::PH_LIT;
								phase_ticks_n    = '0;
								flashes_done_n   = '0;
								flashes_target_n = restart_code;
								led_n            = fbcs_pkg::LED_RED;
								if (code == general_q)
									detail_index_n = detail_next;
							end
						end
						default: phase_n = fbcs_pkg::PH_LIT;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_seen_q      <= '0;
			series_active_q  <= 1'b0;
			phase_q          <= fbcs_pkg::PH_LIT;
			phase_ticks_q    <= '0;
			flashes_done_q   <= '0;
			flashes_target_q <= '0;
			detail_index_q   <= '0;
			alt_ticks_q      <= '0;
			alt_flip_q       <= 1'b0;
			button_last_q    <= 1'b0;
			press_ticks_q    <= '0;
			led_q            <= fbcs_pkg::LED_OFF;
		end else if (in_acc) begin
			code_seen_q      <= code_seen_n;
			series_active_q  <= series_active_n;
			phase_q          <= phase_n;
			phase_ticks_q    <= phase_ticks_n;
			flashes_done_q   <= flashes_done_n;
			flashes_target_q <= flashes_target_n;
			detail_index_q   <= detail_index_n;
			alt_ticks_q      <= alt_ticks_n;
			alt_flip_q       <= alt_flip_n;
			button_last_q    <= button_last_n;
			press_ticks_q    <= press_ticks_n;
			led_q            <= led_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q.red_led           <= led_n[0];
			out_data_q.green_led         <= led_n[1];
			out_data_q.start_calibration <= cal_n;
		end
	end

endmodule

`default_nettype wire

@@ design/fbcs_checker.sv @@
// ----------------------------------------------------------------------------
// fbcs_checker: port-level checks of the fault blink-code sequencer
// Watches the request channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbcs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire fbcs_pkg::in_t               in_data,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire fbcs_pkg::out_t              out_data,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [fbcs_pkg::ADDR_W-1:0] paddr,
	input wire logic [fbcs_pkg::DATA_W-1:0] pwdata,
	input wire logic [fbcs_pkg::DATA_W-1:0] prdata,
	input wire logic                        pready
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// every accepted request leaves a result behind
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	// code zero turns everything off
	a_code_zero_dark: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.fault_code == fbcs_pkg::CODE_NONE |=>
		!out_data.red_led && !out_data.green_led && !out_data.start_calibration)
		else $error("code zero left an output on");

	// calibration needs the button held
	a_cal_needs_button: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.button |=> !out_data.start_calibration)
		else $error("calibration raised with button released");

endmodule

bind fault_blink_code_sequencer fbcs_checker u_fbcs_checker (.*);

`default_nettype wire

@@ sim/fault_blink_code_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// fault_blink_code_sequencer_tb: self-checking bench for the blink-code sequencer
// Drives tick requests and APB register writes, predicts every LED/calibration
// result in lockstep and compares each one as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_blink_code_sequencer_tb;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	fbcs_pkg::in_t                     in_data;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	fbcs_pkg::out_t                    out_data;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [fbcs_pkg::ADDR_W-1:0]       paddr;
	logic [fbcs_pkg::DATA_W-1:0]       pwdata;
	logic [fbcs_pkg::DATA_W-1:0]       prdata;
	logic                              pready;

	fault_blink_code_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// idle rates in percent, zeroed for the stretch with no idling
	int gap_pct   = 13;
	int stall_pct = 13;

	int fail_count     = 0;
	int ticks_sent     = 0;
	int results_seen   = 0;
	int cal_count      = 0;
	int writes_done    = 0;

	// LED results still owed by the block, oldest first
	fbcs_pkg::out_t pending_leds[$];
	fbcs_pkg::out_t want_res;

	// ------------------------------------------------------------------
	// Shadow of the register file and of the sequencer state
	// ------------------------------------------------------------------
	logic [fbcs_pkg::TICK_W-1:0] t_on, t_off, t_pause, t_hold;
	logic [fbcs_pkg::CODE_W-1:0] c_general, c_neutral, c_nogp;

	logic [fbcs_pkg::CODE_W-1:0] m_code;
	logic                        m_running;
	logic [1:0]                  m_phase;
	logic [fbcs_pkg::TICK_W-1:0] m_phase_cnt;
	logic [3:0]                  m_flashes;
	logic [3:0]                  m_target;
	int                          m_detail;
	logic [fbcs_pkg::TICK_W-1:0] m_alt_cnt;
	logic                        m_alt_sel;
	logic                        m_btn_prev;
	logic [fbcs_pkg::TICK_W-1:0] m_hold_cnt;
	logic [1:0]                  m_leds;

	function automatic void reset_model();
		t_on        = fbcs_pkg::RST_ON_MS;
		t_off       = fbcs_pkg::RST_OFF_MS;
		t_pause     = fbcs_pkg::RST_PAUSE_MS;
		t_hold      = fbcs_pkg::RST_LONG_PRESS;
		c_general   = fbcs_pkg::RST_GENERAL;
		c_neutral   = fbcs_pkg::RST_NEUTRAL;
		c_nogp      = fbcs_pkg::RST_NO_GAMEPAD;
		m_code      = fbcs_pkg::CODE_NONE;
		m_running   = 1'b0;
		m_phase     = fbcs_pkg::PH_LIT;
		m_phase_cnt = '0;
		m_flashes   = '0;
		m_target    = '0;
		m_detail    = 0;
		m_alt_cnt   = '0;
		m_alt_sel   = 1'b0;
		m_btn_prev  = 1'b0;
		m_hold_cnt  = '0;
		m_leds      = fbcs_pkg::LED_OFF;
	endfunction

	// new series: first flash lit right away
	function automatic void start_series(input logic [fbcs_pkg::CODE_W-1:0] n);
		m_running   = 1'b1;
		m_phase     = fbcs_pkg::PH_LIT;
		m_phase_cnt = '0;
		m_flashes   = '0;
		m_target    = n;
		m_leds      = fbcs_pkg::LED_RED;
	endfunction

	// One tick of the sequencer: updates the shadow state, returns the LED result
	function automatic fbcs_pkg::out_t next_indication(input fbcs_pkg::in_t tk);
		fbcs_pkg::out_t              r;
		logic                        cal;
		logic [fbcs_pkg::CODE_W-1:0] nxt;
		logic                        found;
		int                          slot;
		r     = '0;
		cal   = 1'b0;
		found = 1'b0;

		// free-running timers, saturating
		if (m_phase_cnt != fbcs_pkg::TICK_MAX) m_phase_cnt = m_phase_cnt + 1'b1;
		if (m_alt_cnt != fbcs_pkg::TICK_MAX)   m_alt_cnt   = m_alt_cnt + 1'b1;
		if (m_hold_cnt != fbcs_pkg::TICK_MAX)  m_hold_cnt  = m_hold_cnt + 1'b1;

		// any code change cancels the series in progress
		if (tk.fault_code != m_code) begin
			m_code    = tk.fault_code;
			m_running = 1'b0;
		end

		if (tk.fault_code == fbcs_pkg::CODE_NONE) begin
			m_running = 1'b0;
			m_leds    = fbcs_pkg::LED_OFF;
		end else begin
			// neutral code is checked first; it overrides the other special codes only while a long press fires
			if (tk.fault_code == c_neutral) begin
				if (tk.button && !m_btn_prev)
					m_hold_cnt = '0;
				if (tk.button && m_btn_prev && m_hold_cnt >= t_hold) begin
					// long press: LEDs frozen, button history untouched
					cal = 1'b1;
				end else begin
					if (!tk.button && m_btn_prev)
						m_hold_cnt = '0;
					m_btn_prev = tk.button;
				end
			end

			if (cal) begin
			end else if (tk.fault_code == c_nogp) begin
				if (m_alt_cnt >= t_on) begin
					m_alt_cnt = '0;
					m_alt_sel = ~m_alt_sel;
				end
				m_leds = m_alt_sel ? fbcs_pkg::LED_GREEN : fbcs_pkg::LED_RED;
			end else begin
				if (!m_running)
					start_series(tk.fault_code);
				case (m_phase)
					fbcs_pkg::PH_LIT: begin
						if (m_phase_cnt >= t_on) begin
							m_leds      = fbcs_pkg::LED_OFF;
							m_phase_cnt = '0;
							m_phase     = fbcs_pkg::PH_DARK;
						end
					end
					fbcs_pkg::PH_DARK: begin
						if (m_phase_cnt >= t_off) begin
							m_flashes   = m_flashes + 1'b1;
							m_phase_cnt = '0;
							if (m_flashes >= m_target) begin
								m_phase = fbcs_pkg::PH_PAUSE;
								m_leds  = fbcs_pkg::LED_OFF;
							end else begin
								m_phase = fbcs_pkg::PH_LIT;
								m_leds  = fbcs_pkg::LED_RED;
							end
						end
					end
					fbcs_pkg::PH_PAUSE: begin
						if (m_phase_cnt >= t_pause) begin
							if (tk.fault_code == c_general) begin
								// round-robin over absent devices: right 2, left 3, pwm 4
								nxt = c_general;
								for (int k = 0; k < 3; k++) begin
									slot = (m_detail + k) % 3;
									if (!found && ((slot == 0 && tk.miss_right) ||
										(slot == 1 && tk.miss_left) ||
										(slot == 2 && tk.miss_pwm))) begin
										m_detail = (slot + 1) % 3;
										nxt      = fbcs_pkg::CODE_W'(slot + 2);
										found    = 1'b1;
									end
								end
								start_series(nxt);
							end else if (tk.miss_right || tk.miss_left || tk.miss_pwm) begin
								start_series(c_general);
							end else begin
								start_series(tk.fault_code);
							end
						end
					end
					default: m_phase = fbcs_pkg::PH_LIT;
				endcase
			end
		end

		r.red_led           = m_leds[0];
		r.green_led         = m_leds[1];
		r.start_calibration = cal;
		return r;
	endfunction

	function automatic fbcs_pkg::in_t mk(input logic [3:0] code, input logic mr,
		input logic ml, input logic mp, input logic btn);
		fbcs_pkg::in_t tk;
		tk.fault_code = code;
		tk.miss_right = mr;
		tk.miss_left  = ml;
		tk.miss_pwm   = mp;
		tk.button     = btn;
		return tk;
	endfunction

	// ------------------------------------------------------------------
	// Clock, receiver back-pressure and result checking
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout at %0t with %0d results outstanding", $time, pending_leds.size());
		$display("Mismatches found");
		$finish;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic check_bit(input string name, input logic exp_v, input logic got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %b actual %b", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_leds.size() == 0) begin
				fail_count++;
				$display("%0t: result with no tick pending, expected none actual %b",
					$time, out_data);
			end else begin
				want_res = pending_leds.pop_front();
				check_bit("red_led", want_res.red_led, out_data.red_led);
				check_bit("green_led", want_res.green_led, out_data.green_led);
				check_bit("start_calibration", want_res.start_calibration,
					out_data.start_calibration);
				if (out_data.start_calibration)
					cal_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request and register access
	// ------------------------------------------------------------------
	task automatic send_tick(input fbcs_pkg::in_t tk);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= tk;
		do @(posedge clk); while (!in_ready);
		pending_leds.push_back(next_indication(tk));
		ticks_sent++;
	endtask

	// drop valid and wait until every owed result has come out
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_leds.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_leds.size() != 0) begin
			fail_count += pending_leds.size();
			$display("%0t: results never arrived, expected %0d more actual 0",
				$time, pending_leds.size());
			pending_leds.delete();
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [fbcs_pkg::DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			fbcs_pkg::REG_ON_MS:      t_on      = val[fbcs_pkg::TICK_W-1:0];
			fbcs_pkg::REG_OFF_MS:     t_off     = val[fbcs_pkg::TICK_W-1:0];
			fbcs_pkg::REG_PAUSE_MS:   t_pause   = val[fbcs_pkg::TICK_W-1:0];
			fbcs_pkg::REG_LONG_PRESS: t_hold    = val[fbcs_pkg::TICK_W-1:0];
			fbcs_pkg::REG_GENERAL:    c_general = val[fbcs_pkg::CODE_W-1:0];
			fbcs_pkg::REG_NEUTRAL:    c_neutral = val[fbcs_pkg::CODE_W-1:0];
			fbcs_pkg::REG_NO_GAMEPAD: c_nogp    = val[fbcs_pkg::CODE_W-1:0];
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic read_reg(input logic [2:0] idx, input logic [fbcs_pkg::DATA_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			fail_count++;
			$display("%0t: register %0d readback mismatch, expected %h actual %h",
				$time, idx, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers();
		read_reg(fbcs_pkg::REG_ON_MS,      {16'd0, t_on});
		read_reg(fbcs_pkg::REG_OFF_MS,     {16'd0, t_off});
		read_reg(fbcs_pkg::REG_PAUSE_MS,   {16'd0, t_pause});
		read_reg(fbcs_pkg::REG_LONG_PRESS, {16'd0, t_hold});
		read_reg(fbcs_pkg::REG_GENERAL,    {28'd0, c_general});
		read_reg(fbcs_pkg::REG_NEUTRAL,    {28'd0, c_neutral});
		read_reg(fbcs_pkg::REG_NO_GAMEPAD, {28'd0, c_nogp});
	endtask

	// all registers, written only once the block has gone quiet
	task automatic configure(input logic [15:0] on_v, input logic [15:0] off_v,
		input logic [15:0] pause_v, input logic [15:0] hold_v,
		input logic [3:0] gen_v, input logic [3:0] neu_v, input logic [3:0] nogp_v);
		settle();
		write_reg(fbcs_pkg::REG_ON_MS,      {16'd0, on_v});
		write_reg(fbcs_pkg::REG_OFF_MS,     {16'd0, off_v});
		write_reg(fbcs_pkg::REG_PAUSE_MS,   {16'd0, pause_v});
		write_reg(fbcs_pkg::REG_LONG_PRESS, {16'd0, hold_v});
		write_reg(fbcs_pkg::REG_GENERAL,    {28'd0, gen_v});
		write_reg(fbcs_pkg::REG_NEUTRAL,    {28'd0, neu_v});
		write_reg(fbcs_pkg::REG_NO_GAMEPAD, {28'd0, nogp_v});
	endtask

	// Runs of one code with slowly changing flags and button, plus some noise.
	// focus gets three runs in ten so the code under test reaches its later phases.
	task automatic random_traffic(input int n, input logic [3:0] focus);
		logic [3:0] code;
		logic [2:0] miss;
		logic       btn;
		int         run_len;
		btn = 1'b0;
		while (n > 0) begin
			case ($urandom_range(9))
				0:       code = fbcs_pkg::CODE_NONE;
				1:       code = c_general;
				2:       code = c_neutral;
				3:       code = c_nogp;
				4, 5, 6: code = focus;
				default: code = 4'($urandom_range(15, 1));
			endcase
			miss    = ($urandom_range(2) == 0) ? 3'b000 : 3'($urandom);
			run_len = $urandom_range(50, 3);
			for (int i = 0; i < run_len && n > 0; i++) begin
				if ($urandom_range(99) < 8) begin
					send_tick(fbcs_pkg::in_t'(8'($urandom)));
				end else begin
					if ($urandom_range(99) < 8)  miss = 3'($urandom);
					if ($urandom_range(99) < 15) btn  = ~btn;
					send_tick(mk(code, miss[2], miss[1], miss[0], btn));
				end
				n--;
			end
		end
	endtask

	function automatic logic [15:0] short_span();
		return 16'($urandom_range(4, 1));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset values read back, then a few ticks at the default timing
	task automatic test_reset_state();
		check_registers();
		send_tick(mk(fbcs_pkg::RST_GENERAL, 1'b1, 1'b0, 1'b1, 1'b0));
		send_tick(mk(fbcs_pkg::RST_GENERAL, 1'b1, 1'b0, 1'b1, 1'b0));
		send_tick(mk(fbcs_pkg::RST_NO_GAMEPAD, 1'b0, 1'b0, 1'b0, 1'b1));
		send_tick(mk(fbcs_pkg::RST_NEUTRAL, 1'b0, 1'b0, 1'b0, 1'b1));
		send_tick(mk(fbcs_pkg::CODE_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	// extremes of every register, each read back after the write
	task automatic test_register_access();
		configure(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 4'd15, 4'd1, 4'd15);
		check_registers();
		configure(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 4'd1, 4'd15, 4'd1);
		check_registers();
	endtask

	// field extremes, every kind of code, long press, code change mid-series
	task automatic test_directed_edges();
		configure(16'd1, 16'd1, 16'd1, 16'd1, fbcs_pkg::RST_GENERAL,
			fbcs_pkg::RST_NEUTRAL, fbcs_pkg::RST_NO_GAMEPAD);
		repeat (3) send_tick(mk(4'd15, 1'b1, 1'b1, 1'b1, 1'b1));
		repeat (2) send_tick(mk(fbcs_pkg::CODE_NONE, 1'b1, 1'b1, 1'b1, 1'b1));
		repeat (4) send_tick(mk(4'd1, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (6) send_tick(mk(c_general, 1'b1, 1'b1, 1'b1, 1'b0));
		repeat (4) send_tick(mk(c_neutral, 1'b0, 1'b0, 1'b0, 1'b1));
		send_tick(mk(c_neutral, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (3) send_tick(mk(c_nogp, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(mk(fbcs_pkg::CODE_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	// flash series and detail cycling over several timing/code settings
	task automatic test_series_random();
		configure(16'd1, 16'd1, 16'd1, 16'd2, 4'd15, 4'd1, 4'd8);
		random_traffic(36, c_general);
		configure(16'd2, 16'd1, 16'd3, 16'd3, 4'd2, 4'd7, 4'd8);
		random_traffic(36, c_general);
		repeat (3) begin
			configure(short_span(), short_span(), short_span(), short_span(),
				4'($urandom_range(15, 1)), 4'($urandom_range(15, 1)),
				4'($urandom_range(15, 1)));
			random_traffic(36, c_general);
		end
	endtask

	// button holds under the neutral code, short and random thresholds
	task automatic test_long_press();
		configure(16'd2, 16'd1, 16'd2, 16'd1, fbcs_pkg::RST_GENERAL,
			fbcs_pkg::RST_NEUTRAL, fbcs_pkg::RST_NO_GAMEPAD);
		random_traffic(30, c_neutral);
		configure(short_span(), short_span(), short_span(), 16'($urandom_range(8, 2)),
			fbcs_pkg::RST_GENERAL, 4'($urandom_range(15, 1)), fbcs_pkg::RST_NO_GAMEPAD);
		random_traffic(30, c_neutral);
	endtask

	task automatic test_alternation();
		configure(16'($urandom_range(3, 1)), 16'd1, 16'd1, 16'd2,
			fbcs_pkg::RST_GENERAL, fbcs_pkg::RST_NEUTRAL, 4'($urandom_range(15, 1)));
		random_traffic(40, c_nogp);
	endtask

	// overlapping special codes: neutral, then no-gamepad, then series
	task automatic test_code_collisions();
		configure(16'd2, 16'd1, 16'd2, 16'd3, 4'd9, 4'd9, 4'd9);
		random_traffic(30, c_general);
		configure(16'd1, 16'd2, 16'd1, 16'd2, 4'd6, 4'd3, 4'd3);
		random_traffic(30, c_neutral);
	endtask

	// zero timing registers end phases at once; general code 0 gives an empty target
	task automatic test_zero_timing();
		configure(16'd0, 16'd0, 16'd0, 16'd0, fbcs_pkg::CODE_NONE,
			fbcs_pkg::RST_NEUTRAL, fbcs_pkg::RST_NO_GAMEPAD);
		random_traffic(30, 4'($urandom_range(15, 1)));
	endtask

	// long stretch with no input gaps and no receiver stalls
	task automatic test_back_to_back();
		configure(16'd2, 16'd1, 16'd2, 16'd2, fbcs_pkg::RST_GENERAL,
			fbcs_pkg::RST_NEUTRAL, fbcs_pkg::RST_NO_GAMEPAD);
		gap_pct   = 0;
		stall_pct = 0;
		random_traffic(60, c_general);
		settle();
		gap_pct   = 13;
		stall_pct = 13;
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		reset_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_register_access();
		test_directed_edges();
		test_series_random();
		test_long_press();
		test_alternation();
		test_code_collisions();
		test_zero_timing();
		test_back_to_back();
		settle();

		$display("Covered %0d tick requests, %0d results and %0d register writes",
			ticks_sent, results_seen, writes_done);
		$display("Long-press calibration raised on %0d ticks, plus a gap-free stretch",
			cal_count);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
